// File: hdl/afbd_pkg.sv
// Package for the audio frame beat detector.
// Holds shared widths, constants and the request and result types; depends on nothing.
package afbd_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned SUM_W    = 17;
  localparam int unsigned MAG_W    = 8;

  localparam int unsigned FRAME_SAMPLES = 576;

  localparam logic [SUM_W-1:0] SUM_MAX        = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] MIN_ENERGY_RST = SUM_W'(FRAME_SAMPLES * 16);

  localparam int unsigned AP_KEEP    = 125;
  localparam int unsigned AP_BLEND   = 3;
  localparam int unsigned AP_SHIFT   = 7;
  localparam int unsigned THR_MUL    = 34;
  localparam int unsigned THR_SHIFT  = 5;
  localparam int unsigned DECAY_MUL  = 14;
  localparam int unsigned DECAY_SHIFT = 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
    logic                       frame_end;
  } item_t;

  typedef struct packed {
    logic             beat;
    logic [SUM_W-1:0] frame_energy;
  } result_t;

endpackage

// File: hdl/afbd_in_stage.sv
// Input register stage of the beat detector.
// Captures one request per cycle unless in_stall is raised, and holds it until the tracker takes it; uses afbd_pkg.
module afbd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  afbd_pkg::item_t in_item,
  input  logic            take,
  output logic            held_valid,
  output afbd_pkg::item_t held_item
);
  import afbd_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall   = valid_r && !take;
  assign load       = in_valid && !in_stall;
  assign valid_nxt  = load ? 1'b1 : (take ? 1'b0 : valid_r);
  assign held_valid = valid_r;
  assign held_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

// File: hdl/afbd_tracker.sv
// Channel sums and peak trackers of the beat detector.
// Accumulates magnitudes and runs the frame-end update; uses afbd_pkg.
module afbd_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  afbd_pkg::item_t              item,
  input  logic [afbd_pkg::SUM_W-1:0]   min_energy,
  output afbd_pkg::result_t            result
);
  import afbd_pkg::*;

  logic [SUM_W-1:0] left_sum_r, left_sum_nxt;
  logic [SUM_W-1:0] right_sum_r, right_sum_nxt;
  logic [SUM_W-1:0] avg_peak_r, avg_peak_nxt;
  logic [SUM_W-1:0] dec_peak_r, dec_peak_nxt;
  logic [SUM_W-1:0] last_beat_r, last_beat_nxt;

  logic [MAG_W-1:0]   mag;
  logic [SUM_W-1:0]   acc_in;
  logic [SUM_W:0]     acc_sum;
  logic [SUM_W-1:0]   acc_sat;
  logic [SUM_W-1:0]   left_new, right_new;
  logic [SUM_W-1:0]   energy;
  logic [SUM_W+7:0]   ap_mix;
  logic [SUM_W-1:0]   ap_blend;
  logic [SUM_W+5:0]   thr_prod;
  logic [SUM_W:0]     thr;
  logic               beat;
  logic [SUM_W:0]     beat_avg;
  logic [SUM_W+3:0]   decay_prod;

  always_comb begin
    mag       = item.sample[SAMPLE_W-1] ? MAG_W'(-item.sample) : MAG_W'(item.sample);
    acc_in    = item.channel ? right_sum_r : left_sum_r;
    acc_sum   = {1'b0, acc_in} + (SUM_W+1)'(mag);
    acc_sat   = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
    left_new  = item.channel ? left_sum_r : acc_sat;
    right_new = item.channel ? acc_sat : right_sum_r;
    energy    = (left_new > right_new) ? left_new : right_new;

    ap_mix   = (SUM_W+8)'(avg_peak_r) * (SUM_W+8)'(AP_KEEP)
             + (SUM_W+8)'(dec_peak_r) * (SUM_W+8)'(AP_BLEND);
    ap_blend = ap_mix[AP_SHIFT +: SUM_W];
    thr_prod = (SUM_W+6)'(ap_blend) * (SUM_W+6)'(THR_MUL);
    thr      = thr_prod[THR_SHIFT +: SUM_W+1];
    beat     = ({1'b0, energy} >= thr) && (energy > min_energy);

    beat_avg   = {1'b0, energy} + {1'b0, last_beat_r};
    decay_prod = (SUM_W+4)'(dec_peak_r) * (SUM_W+4)'(DECAY_MUL);

    left_sum_nxt  = left_sum_r;
    right_sum_nxt = right_sum_r;
    avg_peak_nxt  = avg_peak_r;
    dec_peak_nxt  = dec_peak_r;
    last_beat_nxt = last_beat_r;

    if (en) begin
      if (item.frame_end) begin
        left_sum_nxt  = '0;
        right_sum_nxt = '0;
        if (beat) begin
          avg_peak_nxt  = beat_avg[SUM_W:1];
          last_beat_nxt = energy;
        end else begin
          avg_peak_nxt = ap_blend;
          if (energy > dec_peak_r) begin
            dec_peak_nxt = energy;
          end else begin
            dec_peak_nxt = decay_prod[DECAY_SHIFT +: SUM_W];
          end
        end
      end else begin
        left_sum_nxt  = left_new;
        right_sum_nxt = right_new;
      end
    end

    result.beat         = beat;
    result.frame_energy = energy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_sum_r  <= '0;
      right_sum_r <= '0;
      avg_peak_r  <= '0;
      dec_peak_r  <= '0;
      last_beat_r <= '0;
    end else begin
      left_sum_r  <= left_sum_nxt;
      right_sum_r <= right_sum_nxt;
      avg_peak_r  <= avg_peak_nxt;
      dec_peak_r  <= dec_peak_nxt;
      last_beat_r <= last_beat_nxt;
    end
  end

endmodule

// File: hdl/audio_frame_beat_detector_core.sv
// Audio frame beat detector, top level.
// A frame-end request is registered in the input stage, then its result in the output register once taken.
// One request per cycle while no stall holds the flow; the sum and peak update is combinational in the tracker.
// A frame-end request waits in the input register only while an unread result is stalled.
// Reset (rst_n low, synchronous) clears sums, peaks, valids; min_energy returns to 9216.
// Uses afbd_pkg, afbd_in_stage and afbd_tracker.
module audio_frame_beat_detector_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [afbd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               in_channel,
  input  logic                               in_frame_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_beat,
  output logic [afbd_pkg::SUM_W-1:0]         out_frame_energy,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [afbd_pkg::SUM_W-1:0]         cfg_min_energy
);
  import afbd_pkg::*;

  item_t            in_item;
  item_t            held_item;
  logic             held_valid;
  logic             slot_free;
  logic             take;
  result_t          result;
  logic [SUM_W-1:0] min_energy_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;
  logic             out_load;

  assign in_item.sample    = in_sample;
  assign in_item.channel   = in_channel;
  assign in_item.frame_end = in_frame_end;

  assign slot_free = !out_valid_r || !out_stall;
  assign take      = held_valid && (!held_item.frame_end || slot_free);
  assign out_load  = take && held_item.frame_end;

  afbd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  afbd_tracker u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (take),
    .item       (held_item),
    .min_energy (min_energy_r),
    .result     (result)
  );

  assign cfg_ready     = 1'b1;
  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_energy_r <= MIN_ENERGY_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_energy_r <= cfg_min_energy;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_beat         = out_res_r.beat;
  assign out_frame_energy = out_res_r.frame_energy;

endmodule
